>>> rtl/core/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg
// Types, character codes and decode helpers for the radix integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rip_pkg;

   localparam int CHAR_WIDTH = 8;
   localparam int BASE_WIDTH = 5;
   localparam int OUT_WIDTH  = 32;

   typedef logic [CHAR_WIDTH-1:0] char_type;
   typedef logic [BASE_WIDTH-1:0] base_type;

   // parse phases
   typedef enum logic [2:0] {
      PH_SKIP,
      PH_LETTER,
      PH_DIGITS,
      PH_AFTER,
      PH_FAILED
   } parse_phase_type;

   // supported radix codes
   localparam base_type BASE_BIN = 5'd2;
   localparam base_type BASE_OCT = 5'd8;
   localparam base_type BASE_DEC = 5'd10;
   localparam base_type BASE_HEX = 5'd16;

   // digit code for a byte that is no digit in any radix
   localparam base_type DIGIT_NONE = 5'd31;

   // character codes
   localparam char_type CH_MINUS   = 8'h2D;
   localparam char_type CH_PLUS    = 8'h2B;
   localparam char_type CH_ZERO    = 8'h30;
   localparam char_type CH_NINE    = 8'h39;
   localparam char_type CH_UP_A    = 8'h41;
   localparam char_type CH_UP_F    = 8'h46;
   localparam char_type CH_LOW_A   = 8'h61;
   localparam char_type CH_LOW_F   = 8'h66;
   localparam char_type CH_UP_X    = 8'h58;
   localparam char_type CH_LOW_X   = 8'h78;
   localparam char_type CH_UP_B    = 8'h42;
   localparam char_type CH_LOW_B   = 8'h62;
   localparam char_type CH_SPACE   = 8'h20;
   localparam char_type CH_TAB     = 8'h09;
   localparam char_type CH_CR      = 8'h0D;

   // space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_blank(input char_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // digit value of a byte, case-insensitive; DIGIT_NONE if not a digit
   function automatic base_type digit_of(input char_type c);
      base_type d;
      d = DIGIT_NONE;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = BASE_WIDTH'(c - CH_ZERO);
      end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
         d = BASE_WIDTH'(c - CH_UP_A) + 5'd10;
      end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
         d = BASE_WIDTH'(c - CH_LOW_A) + 5'd10;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/rip_req_if.sv
// ----------------------------------------------------------------------------
// rip_req_if
// Character channel: one byte of the number string, or an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface rip_req_if;
   logic                        valid;
   logic                        ready;
   logic [rip_pkg::CHAR_WIDTH-1:0] character;
   logic                        end_of_string;

   modport source (output valid, output character, output end_of_string, input ready);
   modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rip_rsp_if.sv
// ----------------------------------------------------------------------------
// rip_rsp_if
// Result channel: parsed value and well-formed flag for one string.
// ----------------------------------------------------------------------------
`default_nettype none

interface rip_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rip_pkg::OUT_WIDTH-1:0] value;
   logic                              well_formed;

   modport source (output valid, output value, output well_formed, input ready);
   modport sink   (input valid, input value, input well_formed, output ready);
endinterface

`default_nettype wire

>>> rtl/core/radix_integer_text_parser.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// Parses a number string one byte per item in a configured radix, with
// whitespace skip, sign and base prefixes; an end item returns the value.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_if    in    valid/ready    character[7:0], end_of_string
//  rsp_if    out   valid/ready    value[31:0] signed, well_formed
//  csr_*     in    write enable   number_base[4:0]
//
//  One item per cycle while req_if is ready; the parse state updates at the edge that takes a byte.
//  An end item loads the result register, seen on rsp_if in the cycle after.
//  The result register holds while rsp_if is stalled; req_if stays ready as
//  long as that register is empty or being taken in the same cycle.
//  Synchronous reset restores radix 10 and the whitespace-skip phase.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_text_parser #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire rip_pkg::base_type     csr_write_data,
   rip_req_if.sink                    req_if,
   rip_rsp_if.source                  rsp_if
);
   import rip_pkg::*;

   // configuration and parse state
   base_type                base_ff;
   parse_phase_type         phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic                    seen_ff, seen_in;
   logic                    junk_ff, junk_in;

   // result register
   logic                    rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_well_formed_ff, rsp_well_formed_in;

   logic                    accept;
   logic                    end_item;
   char_type                c;
   base_type                digit;
   logic                    is_digit;
   logic [VALUE_WIDTH-1:0]  mac;
   logic [VALUE_WIDTH-1:0]  signed_acc;
   logic                    ok_phase;

   // handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign end_item     = req_if.end_of_string;
   assign c            = req_if.character;

   // digit decode and multiply-accumulate
   assign digit    = digit_of(c);
   assign is_digit = digit < base_ff;
   assign mac      = acc_ff * {{(VALUE_WIDTH-BASE_WIDTH){1'b0}}, base_ff}
                   + {{(VALUE_WIDTH-BASE_WIDTH){1'b0}}, digit};

   // sign applied to the accumulator
   assign signed_acc = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign ok_phase   = (phase_ff == PH_DIGITS) || (phase_ff == PH_AFTER);

   // wrap to VALUE_WIDTH, then sign-extend or truncate to the output width
   generate
      if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
         assign rsp_value_in = ok_phase ? signed_acc[OUT_WIDTH-1:0] : '0;
      end else begin : g_extend
         assign rsp_value_in = ok_phase
            ? {{(OUT_WIDTH-VALUE_WIDTH){signed_acc[VALUE_WIDTH-1]}}, signed_acc}
            : '0;
      end
   endgenerate

   assign rsp_well_formed_in = ok_phase && seen_ff && !junk_ff;

   // next parse state
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      junk_in  = junk_ff;
      if (accept && end_item) begin
         phase_in = PH_SKIP;
         acc_in   = '0;
         neg_in   = 1'b0;
         seen_in  = 1'b0;
         junk_in  = 1'b0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (!is_blank(c)) begin
                  if (base_ff == BASE_DEC) begin
                     phase_in = PH_DIGITS;
                     if ((c == CH_MINUS) || (c == CH_PLUS)) begin
                        neg_in = (c == CH_MINUS);
                     end else if (is_digit) begin
                        acc_in  = mac;
                        seen_in = 1'b1;
                     end else begin
                        junk_in  = 1'b1;
                        phase_in = PH_AFTER;
                     end
                  end else if ((base_ff == BASE_BIN) || (base_ff == BASE_OCT) ||
                               (base_ff == BASE_HEX)) begin
                     if (c != CH_ZERO) begin
                        phase_in = PH_FAILED;
                     end else if (base_ff == BASE_OCT) begin
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_LETTER;
                     end
                  end else begin
                     phase_in = PH_FAILED;
                  end
               end
            end
            PH_LETTER: begin
               if (((base_ff == BASE_BIN) && ((c == CH_LOW_B) || (c == CH_UP_B))) ||
                   ((base_ff == BASE_HEX) && ((c == CH_LOW_X) || (c == CH_UP_X)))) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_FAILED;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  acc_in  = mac;
                  seen_in = 1'b1;
               end else begin
                  junk_in  = 1'b1;
                  phase_in = PH_AFTER;
               end
            end
            PH_AFTER, PH_FAILED: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = PH_FAILED;
            end
         endcase
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_DEC;
      end else if (csr_write_en) begin
         base_ff <= csr_write_data;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         junk_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
         junk_ff  <= junk_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && end_item) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && end_item) begin
         rsp_value_ff       <= rsp_value_in;
         rsp_well_formed_ff <= rsp_well_formed_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.value       = rsp_value_ff;
   assign rsp_if.well_formed = rsp_well_formed_ff;

endmodule

`default_nettype wire

>>> test/radix_integer_text_parser_tb.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser_tb
// Self-checking bench for the radix integer parser. Strings are sent one
// byte per item, closed by an end item. A scoreboard predicts the value
// and well-formed flag of every string and checks each returned result.
// The run starts with short directed strings in the reset radix. It then
// sweeps the supported radixes and several unsupported ones with random
// clean, truncated and corrupted strings, under three handshake idle mixes.
// ----------------------------------------------------------------------------

import rip_pkg::*;

typedef char_type char_queue [$];

typedef struct packed {
   logic [OUT_WIDTH-1:0] value;
   logic                 well_formed;
} parse_result_type;

// scoreboard: tracks the parse of the current string, queues expected results
class parse_tracker;
   localparam char_type CH_NL = 8'h0A;
   localparam char_type CH_VT = 8'h0B;
   localparam char_type CH_FF = 8'h0C;

   base_type             radix;
   parse_phase_type      phase;
   logic [OUT_WIDTH-1:0] accum;
   bit                   negative;
   bit                   digit_seen;
   bit                   junk;
   parse_result_type     expected_parses [$];
   int                   errors;
   int                   chars_taken;
   int                   strings_checked;
   int                   good_strings;

   function new();
      radix = BASE_DEC;
      errors = 0;
      chars_taken = 0;
      strings_checked = 0;
      good_strings = 0;
      restart();
   endfunction

   function void restart();
      phase = PH_SKIP;
      accum = '0;
      negative = 1'b0;
      digit_seen = 1'b0;
      junk = 1'b0;
   endfunction

   function void set_radix(base_type b);
      radix = b;
   endfunction

   function int pending();
      return expected_parses.size();
   endfunction

   // value of a hex digit in either case, -1 for any other byte
   function int digit_value(char_type c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
      return -1;
   endfunction

   // accumulate one digit, or stop at the first non-digit
   function void take_digit(char_type c);
      int d;
      d = digit_value(c);
      if (d >= 0 && d < int'(radix)) begin
         accum = accum * OUT_WIDTH'(radix) + OUT_WIDTH'(d);
         digit_seen = 1'b1;
      end else begin
         junk = 1'b1;
         phase = PH_AFTER;
      end
   endfunction

   // note one accepted item and predict its effect
   function void predict_char(char_type c, logic eos);
      parse_result_type res;
      chars_taken++;
      if (eos) begin
         res.value = '0;
         res.well_formed = 1'b0;
         if (phase == PH_DIGITS || phase == PH_AFTER) begin
            res.value = negative ? -accum : accum;
            res.well_formed = digit_seen && !junk;
         end
         expected_parses.push_back(res);
         restart();
         return;
      end
      case (phase)
         PH_SKIP: begin
            if (!(c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR})) begin
               if (radix == BASE_DEC) begin
                  phase = PH_DIGITS;
                  if (c == CH_MINUS || c == CH_PLUS) begin
                     negative = (c == CH_MINUS);
                  end else begin
                     take_digit(c);
                  end
               end else if (radix == BASE_BIN || radix == BASE_OCT || radix == BASE_HEX) begin
                  if (c != CH_ZERO) phase = PH_FAILED;
                  else phase = (radix == BASE_OCT) ? PH_DIGITS : PH_LETTER;
               end else begin
                  phase = PH_FAILED;
               end
            end
         end
         PH_LETTER: begin
            if ((radix == BASE_BIN && (c == CH_LOW_B || c == CH_UP_B)) ||
                (radix == BASE_HEX && (c == CH_LOW_X || c == CH_UP_X)))
               phase = PH_DIGITS;
            else
               phase = PH_FAILED;
         end
         PH_DIGITS: take_digit(c);
         default: ;
      endcase
   endfunction

   // compare one returned result with the oldest prediction
   function void check_result(logic [OUT_WIDTH-1:0] value, logic well_formed);
      parse_result_type want;
      if (expected_parses.size() == 0) begin
         errors++;
         $display("%0t: result with no string pending: expected none, actual %0d/%0b",
                  $time, $signed(value), well_formed);
         return;
      end
      want = expected_parses.pop_front();
      strings_checked++;
      if (want.well_formed) good_strings++;
      if (value !== want.value) begin
         errors++;
         $display("%0t: value mismatch: expected %0d, actual %0d",
                  $time, $signed(want.value), $signed(value));
      end
      if (well_formed !== want.well_formed) begin
         errors++;
         $display("%0t: well_formed mismatch: expected %0b, actual %0b",
                  $time, want.well_formed, well_formed);
      end
   endfunction
endclass

module radix_integer_text_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int NUM_PHASES     = 9;
   localparam int CHARS_SUPPORTED   = 260;
   localparam int CHARS_UNSUPPORTED = 60;

   // radix settings outside the supported four
   localparam base_type BASE_ZERO     = 5'd0;
   localparam base_type BASE_FIVE     = 5'd5;
   localparam base_type BASE_ALL_ONES = 5'd31;

   localparam base_type PHASE_RADIX [NUM_PHASES] = '{
      BASE_HEX, BASE_BIN, BASE_OCT, BASE_ALL_ONES, BASE_DEC,
      BASE_ZERO, BASE_HEX, BASE_FIVE, BASE_DEC};

   localparam char_type BLANK_SET [6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_write_en;
   base_type csr_write_data;

   rip_req_if req_bus ();
   rip_rsp_if rsp_bus ();

   parse_tracker tracker = new();

   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   radix_integer_text_parser dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side backpressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_result(rsp_bus.value, rsp_bus.well_formed);
         if (req_bus.valid && req_bus.ready)
            tracker.predict_char(req_bus.character, req_bus.end_of_string);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("radix_integer_text_parser_tb: done, errors");
            $finish;
         end
      end
   end

   // one item on the character channel, with random idle cycles ahead of it
   task automatic send_item(input char_type c, input logic eos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.character <= c;
      req_bus.end_of_string <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // a whole string followed by an end item with a random byte
   task automatic send_text(input char_queue text);
      foreach (text[i]) send_item(text[i], 1'b0);
      send_item(char_type'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic char_queue chars_of(input string s);
      char_queue q;
      for (int i = 0; i < s.len(); i++) q.push_back(char_type'(s[i]));
      return q;
   endfunction

   // random string for a radix: mostly well formed, some corrupted
   task automatic send_random_string(input base_type radix);
      char_queue text;
      int        ndig;
      int        roll;
      int        cut;
      int        digit_radix;
      int        d;
      // leading whitespace
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(BLANK_SET[$urandom_range(0, 5)]);
      // sign or radix prefix
      case (radix)
         BASE_DEC: begin
            roll = $urandom_range(0, 2);
            if (roll == 1) text.push_back(CH_MINUS);
            else if (roll == 2) text.push_back(CH_PLUS);
         end
         BASE_HEX: begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
         end
         BASE_BIN: begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_UP_B : CH_LOW_B);
         end
         BASE_OCT: text.push_back(CH_ZERO);
         default: if ($urandom_range(0, 1)) text.push_back(CH_ZERO);
      endcase
      // digits, a few long enough to wrap
      roll = $urandom_range(0, 99);
      if (roll < 8) ndig = 0;
      else if (roll < 90) ndig = $urandom_range(1, 10);
      else ndig = $urandom_range(11, 40);
      digit_radix = (radix inside {BASE_BIN, BASE_OCT, BASE_DEC, BASE_HEX}) ? int'(radix) : 16;
      repeat (ndig) begin
         d = $urandom_range(0, digit_radix - 1);
         if (d < 10) text.push_back(char_type'(CH_ZERO + d));
         else text.push_back(char_type'(($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + d - 10));
      end
      // corruption
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
      end else if (roll < 78) begin
         repeat ($urandom_range(1, 3)) text.push_back(char_type'($urandom_range(0, 255)));
      end else if (roll < 86) begin
         text.delete();
         repeat ($urandom_range(1, 6)) text.push_back(char_type'($urandom_range(0, 255)));
      end else if (roll < 93) begin
         if (text.size() > 0) begin
            cut = $urandom_range(0, text.size() - 1);
            while (text.size() > cut) void'(text.pop_back());
         end
      end else if (text.size() > 0) begin
         text[$urandom_range(0, text.size() - 1)] = char_type'($urandom_range(0, 255));
      end
      send_text(text);
   endtask

   // stop sending and let every pending result drain
   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // main sequence
   initial begin
      int budget;
      int regime;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= BASE_DEC;
      req_bus.valid <= 1'b0;
      req_bus.character <= '0;
      req_bus.end_of_string <= 1'b0;
      send_idle_pct = 25;
      recv_stall_pct = 87;
      quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed strings in the reset radix
      send_text(chars_of(" -12"));
      send_text(chars_of("+"));
      send_text(chars_of("7q"));
      send_text(chars_of("9999999999"));
      send_text(chars_of(""));
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b1);

      // random strings over a sweep of radix settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_idle();
         csr_write_en <= 1'b1;
         csr_write_data <= PHASE_RADIX[p];
         @(posedge clock);
         csr_write_en <= 1'b0;
         tracker.set_radix(PHASE_RADIX[p]);
         regime = p / 3;
         case (regime)
            0: begin
               send_idle_pct = 25;
               recv_stall_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         budget = tracker.chars_taken +
                  ((PHASE_RADIX[p] inside {BASE_BIN, BASE_OCT, BASE_DEC, BASE_HEX}) ?
                   CHARS_SUPPORTED : CHARS_UNSUPPORTED);
         while (tracker.chars_taken < budget) send_random_string(PHASE_RADIX[p]);
      end

      wait_for_idle();
      if (tracker.pending() != 0) begin
         tracker.errors++;
         $display("%0t: %0d results never returned", $time, tracker.pending());
      end
      $display("radix_integer_text_parser_tb: %0d items, %0d strings checked (%0d well formed)",
               tracker.chars_taken, tracker.strings_checked, tracker.good_strings);
      $display("radix_integer_text_parser_tb: radix 10 at reset, then 16, 2, 8, 31, 10, 0, 16, 5, 10");
      if (tracker.errors == 0) begin
         $display("radix_integer_text_parser_tb: done, clean");
      end else begin
         $display("radix_integer_text_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
